@@ src/sfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types and byte codes for the serial frame assembler.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam logic [7:0] ChStart = 8'h53;  // S
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChW     = 8'h57;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChV     = 8'h56;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChN     = 8'h4E;

  localparam int unsigned HeaderLen = 3;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_TYPE    = 7'b0000010,
    ST_COUNT   = 7'b0000100,
    ST_PAYLOAD = 7'b0001000,
    ST_STATUS  = 7'b0010000,
    ST_EMIT_RD = 7'b0100000,
    ST_EMIT_WR = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    ADDR_START   = 2'd0,
    ADDR_TYPE    = 2'd1,
    ADDR_COUNT   = 2'd2,
    ADDR_PAYLOAD = 2'd3
  } addr_sel_e;

  typedef enum logic [1:0] {
    LEN_SHORT   = 2'd0,
    LEN_HEADER  = 2'd1,
    LEN_PAYLOAD = 2'd2
  } len_sel_e;

  typedef struct packed {
    logic      wr_en;
    addr_sel_e wr_sel;
    logic      decl_load;
    logic      rcv_clear;
    logic      rcv_inc;
    logic      len_load;
    len_sel_e  len_sel;
    logic      idx_clear;
    logic      rd_en;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_cnt_type;
    logic is_now_type;
    logic is_stat_type;
    logic is_status_ok;
    logic is_zero;
    logic keep;
    logic payload_done;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

@@ src/serial_frame_assembler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_assembler_unit
// Parses framed serial byte streams and replays each finished frame.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while a frame is being collected.
// Once a frame completes, the input is held off while the frame is replayed
// from the message store: each output beat is a store read, then a load into
// the output register, so a frame of n bytes (2 to MAX_PAYLOAD+3) blocks the
// input until its last beat is loaded, longer if the sink stalls. The last
// output beat may still wait in the output register while the next frame is
// collected. The store needs no clearing after reset.
module serial_frame_assembler_unit #(
  parameter int unsigned MAX_PAYLOAD = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       msg_valid_o,
  input  logic       msg_ready_i,
  output logic [7:0] msg_byte_o,
  output logic       msg_last_o
);

  sfa_pkg::cmd_t    cmd;
  sfa_pkg::status_t status;

  sfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_valid_i(rx_valid_i),
    .rx_ready_o(rx_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sfa_datapath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .msg_ready_i(msg_ready_i),
    .msg_valid_o(msg_valid_o),
    .msg_byte_o (msg_byte_o),
    .msg_last_o (msg_last_o)
  );

endmodule

@@ src/sfa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sfa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_datapath
// Byte decode, counters, message store and output register.
// ----------------------------------------------------------------------------
module sfa_datapath #(
  parameter int unsigned MAX_PAYLOAD = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  sfa_pkg::cmd_t    cmd_i,
  output sfa_pkg::status_t status_o,
  input  logic             msg_ready_i,
  output logic             msg_valid_o,
  output logic [7:0]       msg_byte_o,
  output logic             msg_last_o
);

  localparam int unsigned Depth = MAX_PAYLOAD + sfa_pkg::HeaderLen;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned LW    = $clog2(Depth + 1);

  logic [7:0]    decl_q;
  logic [7:0]    rcv_q;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] idx_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic [8:0]    rcv_nxt;
  logic [8:0]    kept;
  logic [AW-1:0] waddr;
  logic [7:0]    rdata;

  assign rcv_nxt = {1'b0, rcv_q} + 9'd1;
  assign kept    = (rcv_nxt < 9'(MAX_PAYLOAD)) ? rcv_nxt : 9'(MAX_PAYLOAD);

  always_comb begin
    status_o              = '0;
    status_o.is_start     = (rx_byte_i == sfa_pkg::ChStart);
    status_o.is_cnt_type  = (rx_byte_i == sfa_pkg::ChL) || (rx_byte_i == sfa_pkg::ChM) ||
                            (rx_byte_i == sfa_pkg::ChW);
    status_o.is_now_type  = (rx_byte_i == sfa_pkg::ChO) || (rx_byte_i == sfa_pkg::ChX);
    status_o.is_stat_type = (rx_byte_i == sfa_pkg::ChV) || (rx_byte_i == sfa_pkg::ChE) ||
                            (rx_byte_i == sfa_pkg::ChP) || (rx_byte_i == sfa_pkg::ChA);
    status_o.is_status_ok = (rx_byte_i == sfa_pkg::ChV) || (rx_byte_i == sfa_pkg::ChC) ||
                            (rx_byte_i == sfa_pkg::ChP) || (rx_byte_i == sfa_pkg::ChStart) ||
                            (rx_byte_i == sfa_pkg::ChI) || (rx_byte_i == sfa_pkg::ChN);
    status_o.is_zero      = (rx_byte_i == 8'd0);
    status_o.keep         = (rcv_q < 8'(MAX_PAYLOAD));
    status_o.payload_done = (rcv_nxt >= {1'b0, decl_q});
    status_o.emit_last    = ((LW'(idx_q) + LW'(1)) == len_q);
    status_o.out_free     = !out_valid_q || msg_ready_i;
  end

  always_comb begin
    case (cmd_i.wr_sel)
      sfa_pkg::ADDR_START:   waddr = AW'(0);
      sfa_pkg::ADDR_TYPE:    waddr = AW'(1);
      sfa_pkg::ADDR_COUNT:   waddr = AW'(2);
      sfa_pkg::ADDR_PAYLOAD: waddr = AW'(rcv_q) + AW'(sfa_pkg::HeaderLen);
      default:               waddr = AW'(0);
    endcase
  end

  always_comb begin
    case (cmd_i.len_sel)
      sfa_pkg::LEN_SHORT:   len_d = LW'(2);
      sfa_pkg::LEN_HEADER:  len_d = LW'(sfa_pkg::HeaderLen);
      sfa_pkg::LEN_PAYLOAD: len_d = LW'(kept) + LW'(sfa_pkg::HeaderLen);
      default:              len_d = LW'(sfa_pkg::HeaderLen);
    endcase
  end

  sfa_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q      <= '0;
      rcv_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decl_load) begin
        decl_q <= rx_byte_i;
      end
      if (cmd_i.rcv_clear) begin
        rcv_q <= '0;
      end else if (cmd_i.rcv_inc) begin
        rcv_q <= rcv_nxt[7:0];
      end
      if (cmd_i.len_load) begin
        len_q <= len_d;
      end
      if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.out_load) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (msg_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= rdata;
      out_last_q <= status_o.emit_last;
    end
  end

  assign msg_valid_o = out_valid_q;
  assign msg_byte_o  = out_byte_q;
  assign msg_last_o  = out_last_q;

endmodule

@@ src/sfa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfa_ctrl
// Frame parsing and emission state machine.
// ----------------------------------------------------------------------------
module sfa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  input  sfa_pkg::status_t status_i,
  output sfa_pkg::cmd_t    cmd_o
);

  sfa_pkg::state_e state_q, state_d;
  logic            acc;

  assign rx_ready_o = (state_q == sfa_pkg::ST_IDLE) || (state_q == sfa_pkg::ST_TYPE) ||
                      (state_q == sfa_pkg::ST_COUNT) || (state_q == sfa_pkg::ST_PAYLOAD) ||
                      (state_q == sfa_pkg::ST_STATUS);
  assign acc = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      sfa_pkg::ST_IDLE: begin
        if (acc && status_i.is_start) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = sfa_pkg::ADDR_START;
          state_d      = sfa_pkg::ST_TYPE;
        end
      end
      sfa_pkg::ST_TYPE: begin
        cmd_o.wr_sel = sfa_pkg::ADDR_TYPE;
        if (acc) begin
          if (status_i.is_cnt_type) begin
            cmd_o.wr_en = 1'b1;
            state_d     = sfa_pkg::ST_COUNT;
          end else if (status_i.is_now_type) begin
            cmd_o.wr_en     = 1'b1;
            cmd_o.len_load  = 1'b1;
            cmd_o.len_sel   = sfa_pkg::LEN_SHORT;
            cmd_o.idx_clear = 1'b1;
            state_d         = sfa_pkg::ST_EMIT_RD;
          end else if (status_i.is_stat_type) begin
            cmd_o.wr_en = 1'b1;
            state_d     = sfa_pkg::ST_STATUS;
          end
        end
      end
      sfa_pkg::ST_COUNT: begin
        if (acc) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = sfa_pkg::ADDR_COUNT;
          cmd_o.decl_load = 1'b1;
          cmd_o.rcv_clear = 1'b1;
          if (status_i.is_zero) begin
            cmd_o.len_load  = 1'b1;
            cmd_o.len_sel   = sfa_pkg::LEN_HEADER;
            cmd_o.idx_clear = 1'b1;
            state_d         = sfa_pkg::ST_EMIT_RD;
          end else begin
            state_d = sfa_pkg::ST_PAYLOAD;
          end
        end
      end
      sfa_pkg::ST_PAYLOAD: begin
        cmd_o.wr_sel = sfa_pkg::ADDR_PAYLOAD;
        if (acc) begin
          cmd_o.wr_en   = status_i.keep;
          cmd_o.rcv_inc = 1'b1;
          if (status_i.payload_done) begin
            cmd_o.len_load  = 1'b1;
            cmd_o.len_sel   = sfa_pkg::LEN_PAYLOAD;
            cmd_o.idx_clear = 1'b1;
            state_d         = sfa_pkg::ST_EMIT_RD;
          end
        end
      end
      sfa_pkg::ST_STATUS: begin
        if (acc) begin
          if (status_i.is_status_ok) begin
            cmd_o.wr_en     = 1'b1;
            cmd_o.wr_sel    = sfa_pkg::ADDR_COUNT;
            cmd_o.len_load  = 1'b1;
            cmd_o.len_sel   = sfa_pkg::LEN_HEADER;
            cmd_o.idx_clear = 1'b1;
            state_d         = sfa_pkg::ST_EMIT_RD;
          end else begin
            state_d = sfa_pkg::ST_IDLE;
          end
        end
      end
      sfa_pkg::ST_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = sfa_pkg::ST_EMIT_WR;
      end
      sfa_pkg::ST_EMIT_WR: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = status_i.emit_last ? sfa_pkg::ST_IDLE : sfa_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_d = sfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sim/frame_replay_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_replay_checker
// Watches the receive and message channels of the frame assembler, rebuilds
// each frame from the accepted receive beats and checks every replayed beat
// (byte and last flag) in order against the rebuilt frame.
// ----------------------------------------------------------------------------
module frame_replay_checker #(
  parameter int unsigned MAX_PAYLOAD = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        msg_valid_i,
  input  logic        msg_ready_i,
  input  logic [7:0]  msg_byte_i,
  input  logic        msg_last_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned rx_beats_o,
  output int unsigned msg_beats_o,
  output int unsigned frames_o
);

  localparam int unsigned StoreDepth = MAX_PAYLOAD + sfa_pkg::HeaderLen;

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_TYPE,
    PARSE_COUNT,
    PARSE_PAYLOAD,
    PARSE_STATUS
  } parse_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } beat_t;

  parse_e     parse_state;
  logic [7:0] declared_len;
  logic [7:0] payload_seen;
  logic [7:0] frame_buf [StoreDepth];
  beat_t      expected_beats [$];

  function automatic bit is_count_type(input logic [7:0] b);
    return (b == sfa_pkg::ChL) || (b == sfa_pkg::ChM) || (b == sfa_pkg::ChW);
  endfunction

  function automatic bit is_short_type(input logic [7:0] b);
    return (b == sfa_pkg::ChO) || (b == sfa_pkg::ChX);
  endfunction

  function automatic bit is_status_type(input logic [7:0] b);
    return (b == sfa_pkg::ChV) || (b == sfa_pkg::ChE) || (b == sfa_pkg::ChP) ||
           (b == sfa_pkg::ChA);
  endfunction

  function automatic bit is_good_status(input logic [7:0] b);
    return (b == sfa_pkg::ChV) || (b == sfa_pkg::ChC) || (b == sfa_pkg::ChP) ||
           (b == sfa_pkg::ChStart) || (b == sfa_pkg::ChI) || (b == sfa_pkg::ChN);
  endfunction

  task automatic flag_error(input string what);
    $display("%0t ns  error: %s", $time, what);
    errors_o++;
  endtask

  task automatic queue_frame(input int unsigned len);
    beat_t b;
    for (int unsigned k = 0; k < len; k++) begin
      b.data    = frame_buf[k];
      b.is_last = (k + 1 == len);
      expected_beats.push_back(b);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int unsigned kept;
    case (parse_state)
      PARSE_IDLE: begin
        if (b == sfa_pkg::ChStart) parse_state = PARSE_TYPE;
      end
      PARSE_TYPE: begin
        if (is_count_type(b) || is_short_type(b) || is_status_type(b)) begin
          frame_buf[0] = sfa_pkg::ChStart;
          frame_buf[1] = b;
          if (is_count_type(b)) begin
            parse_state = PARSE_COUNT;
          end else if (is_status_type(b)) begin
            parse_state = PARSE_STATUS;
          end else begin
            parse_state = PARSE_IDLE;
            queue_frame(2);
          end
        end
      end
      PARSE_COUNT: begin
        declared_len = b;
        frame_buf[2] = b;
        payload_seen = '0;
        if (b == 8'h00) begin
          parse_state = PARSE_IDLE;
          queue_frame(sfa_pkg::HeaderLen);
        end else begin
          parse_state = PARSE_PAYLOAD;
        end
      end
      PARSE_PAYLOAD: begin
        if (payload_seen < MAX_PAYLOAD) frame_buf[sfa_pkg::HeaderLen + payload_seen] = b;
        payload_seen = payload_seen + 8'd1;
        if (payload_seen >= declared_len) begin
          kept = (payload_seen < MAX_PAYLOAD) ? payload_seen : MAX_PAYLOAD;
          parse_state = PARSE_IDLE;
          queue_frame(sfa_pkg::HeaderLen + kept);
        end
      end
      PARSE_STATUS: begin
        parse_state = PARSE_IDLE;
        if (is_good_status(b)) begin
          frame_buf[2] = b;
          queue_frame(sfa_pkg::HeaderLen);
        end
      end
      default: parse_state = PARSE_IDLE;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    if (!rst_ni) begin
      parse_state  = PARSE_IDLE;
      declared_len = '0;
      payload_seen = '0;
      expected_beats.delete();
      errors_o     = 0;
      pending_o    = 0;
      rx_beats_o   = 0;
      msg_beats_o  = 0;
      frames_o     = 0;
    end else begin
      if (msg_valid_i && msg_ready_i) begin
        msg_beats_o++;
        if (msg_last_i) frames_o++;
        if (expected_beats.size() == 0) begin
          flag_error($sformatf("unexpected beat byte=%02h last=%0b", msg_byte_i, msg_last_i));
        end else begin
          want = expected_beats.pop_front();
          if (msg_byte_i !== want.data)
            flag_error($sformatf("msg_byte %02h, wanted %02h", msg_byte_i, want.data));
          if (msg_last_i !== want.is_last)
            flag_error($sformatf("msg_last %0b, wanted %0b (byte %02h)",
                                 msg_last_i, want.is_last, want.data));
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        rx_beats_o++;
        absorb_byte(rx_byte_i);
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for serial_frame_assembler_unit.
// ----------------------------------------------------------------------------
// A short directed stream covers idle noise, a repeated start, an unknown type,
// short frames, a zero count and a dropped status frame. Random frames follow,
// mostly well formed with random content, the rest noise or truncated. Both
// channels idle and stall at random; a separate checker compares every beat.
module tb;

  localparam int unsigned MaxPayload  = 12;
  localparam int unsigned TargetItems = 410;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 64;

  localparam logic [7:0] FrameTypes [9] = '{
    sfa_pkg::ChL, sfa_pkg::ChM, sfa_pkg::ChW, sfa_pkg::ChO, sfa_pkg::ChX,
    sfa_pkg::ChV, sfa_pkg::ChE, sfa_pkg::ChP, sfa_pkg::ChA
  };
  localparam logic [7:0] StatusCodes [6] = '{
    sfa_pkg::ChV, sfa_pkg::ChC, sfa_pkg::ChP, sfa_pkg::ChStart, sfa_pkg::ChI, sfa_pkg::ChN
  };
  localparam logic [7:0] OpeningStream [25] = '{
    8'h00, 8'hFF,
    sfa_pkg::ChStart, sfa_pkg::ChStart, 8'h7F, sfa_pkg::ChO,
    sfa_pkg::ChStart, sfa_pkg::ChX,
    sfa_pkg::ChStart, sfa_pkg::ChV, sfa_pkg::ChC,
    sfa_pkg::ChStart, sfa_pkg::ChE, 8'h51,
    sfa_pkg::ChStart, sfa_pkg::ChL, 8'h00,
    sfa_pkg::ChStart, sfa_pkg::ChW, 8'h02, 8'h00, 8'hFF,
    sfa_pkg::ChStart, sfa_pkg::ChA, sfa_pkg::ChN
  };

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       rx_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       msg_ready = 1'b0;
  logic       rx_ready;
  logic       msg_valid;
  logic [7:0] msg_byte;
  logic       msg_last;

  int unsigned errors;
  int unsigned pending;
  int unsigned rx_beats;
  int unsigned msg_beats;
  int unsigned frames;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  serial_frame_assembler_unit #(
    .MAX_PAYLOAD(MaxPayload)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_valid_i (rx_valid),
    .rx_ready_o (rx_ready),
    .rx_byte_i  (rx_byte),
    .msg_valid_o(msg_valid),
    .msg_ready_i(msg_ready),
    .msg_byte_o (msg_byte),
    .msg_last_o (msg_last)
  );

  frame_replay_checker #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_replay_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_valid_i (rx_valid),
    .rx_ready_i (rx_ready),
    .rx_byte_i  (rx_byte),
    .msg_valid_i(msg_valid),
    .msg_ready_i(msg_ready),
    .msg_byte_i (msg_byte),
    .msg_last_i (msg_last),
    .errors_o   (errors),
    .pending_o  (pending),
    .rx_beats_o (rx_beats),
    .msg_beats_o(msg_beats),
    .frames_o   (frames)
  );

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned sink_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned payload_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(1, MaxPayload);
    if (r < 98) return $urandom_range(MaxPayload + 1, 2 * MaxPayload);
    return $urandom_range(100, 255);
  endfunction

  function automatic bit is_frame_type(input logic [7:0] b);
    foreach (FrameTypes[i]) if (FrameTypes[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit counted, input bit no_gaps);
    int unsigned gap;
    rx_byte  <= b;
    rx_valid <= 1'b1;
    do @(posedge clk); while (!rx_ready);
    if (counted) items_sent++;
    gap = no_gaps ? 0 : sender_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    rx_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic send_frame(input bit no_gaps);
    int unsigned r;
    int unsigned len;
    int unsigned sent_len;
    logic [7:0]  ftype;
    logic [7:0]  junk;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, no_gaps);
    end else begin
      send_byte(sfa_pkg::ChStart, 1'b1, no_gaps);
      if ($urandom_range(0, 7) == 0) begin
        do junk = 8'($urandom_range(0, 255)); while (is_frame_type(junk));
        send_byte(junk, 1'b1, no_gaps);
      end
      ftype = FrameTypes[$urandom_range(0, 8)];
      send_byte(ftype, 1'b1, no_gaps);
      if (ftype == sfa_pkg::ChL || ftype == sfa_pkg::ChM || ftype == sfa_pkg::ChW) begin
        len = payload_len();
        send_byte(8'(len), 1'b1, no_gaps);
        // truncated frames leave the parser mid payload
        sent_len = (r >= 90 && len > 1) ? $urandom_range(1, len - 1) : len;
        repeat (sent_len) send_byte(8'($urandom_range(0, 255)), 1'b1, no_gaps);
      end else if (ftype != sfa_pkg::ChO && ftype != sfa_pkg::ChX && r < 90) begin
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1, no_gaps);
        else send_byte(StatusCodes[$urandom_range(0, 5)], 1'b1, no_gaps);
      end
    end
  endtask

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      msg_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if ($urandom_range(0, 4) != 0) begin
        msg_ready <= 1'b0;
        repeat (sink_stall()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_valid && rx_ready) || (msg_valid && msg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no beat moved for %0d cycles, %0d beats still expected",
               StallLimit, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    bit paused_mid;
    paused_mid = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OpeningStream[i]) send_byte(OpeningStream[i], 1'b1, 1'b0);
    wait_drained();

    while (items_sent < TargetItems) begin
      send_frame($urandom_range(0, 3) == 0);
      if (!paused_mid && items_sent >= TargetItems / 2) begin
        paused_mid = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d received bytes and %0d replayed frames (%0d message beats)",
             rx_beats, frames, msg_beats);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d beats never seen", errors, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
